// File: src/mvt_pkg.sv
// ---------------------------------------------------------------------------
// mvt_pkg: shared definitions for the matrix vector transform
// Field widths, op codes, register reset values and inter-module types.
// ---------------------------------------------------------------------------
package mvt_pkg;

  localparam int FIELD_W     = 32;
  localparam int CFG_W       = 64;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int CFG_IDX_W   = REG_IDX_W + 1;
  localparam int NUM_LANES   = 4;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;

  localparam logic [1:0] OP_AFFINE = 2'd0;
  localparam logic [1:0] OP_COLUMN = 2'd1;
  localparam logic [1:0] OP_ROW    = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Identity matrix in Q16.16.
  localparam logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  // Raw 32-bit coefficient slots, indexed [row][column].
  typedef logic [NUM_LANES-1:0][NUM_LANES-1:0][FIELD_W-1:0] coef_mat_t;

  // Tag that travels alongside each pipeline stage.
  typedef struct packed {
    logic vld;
    logic zero;
  } pipe_tag_t;

  // One lane's finished component.
  typedef struct packed {
    logic [FIELD_W-1:0] word;
    logic               sat;
  } lane_res_t;

endpackage

// File: src/mvt_coef_bank.sv
// ---------------------------------------------------------------------------
// mvt_coef_bank: coefficient registers
// Eight 64-bit configuration registers unpacked into a 4x4 coefficient grid.
// ---------------------------------------------------------------------------
module mvt_coef_bank (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [mvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mvt_pkg::CFG_W-1:0]     cfg_wdata,
  output mvt_pkg::coef_mat_t            coef
);

  logic [mvt_pkg::CFG_W-1:0] regs_r [mvt_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mvt_pkg::NUM_REGS; i++) begin
        regs_r[i] <= mvt_pkg::REG_RESET[i];
      end
    end else if (cfg_wr_en &&
                 (cfg_index < mvt_pkg::CFG_IDX_W'(mvt_pkg::NUM_REGS))) begin
      regs_r[cfg_index[mvt_pkg::REG_IDX_W-1:0]] <= cfg_wdata;
    end
  end

  // Register 2r holds columns 0 and 1 of row r, register 2r+1 columns 2 and 3.
  always_comb begin
    for (int r = 0; r < mvt_pkg::NUM_LANES; r++) begin
      for (int c = 0; c < mvt_pkg::NUM_LANES; c++) begin
        if (c % 2 == 1) begin
          coef[r][c] = regs_r[mvt_pkg::REG_IDX_W'(r * 2 + c / 2)][63:32];
        end else begin
          coef[r][c] = regs_r[mvt_pkg::REG_IDX_W'(r * 2 + c / 2)][31:0];
        end
      end
    end
  end

endmodule

// File: src/mvt_lane.sv
// ---------------------------------------------------------------------------
// mvt_lane: one dot-product lane
// Four registered products, a registered sum with rounding offset, then
// shift and saturation to a signed word.
// ---------------------------------------------------------------------------
module mvt_lane #(
  parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = mvt_pkg::WORD_WIDTH_DEF,
  parameter int MUL_W      = mvt_pkg::WORD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [MUL_W-1:0] opa [mvt_pkg::NUM_LANES],
  input  logic signed [MUL_W-1:0] opb [mvt_pkg::NUM_LANES],
  output mvt_pkg::lane_res_t      res
);

  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = PROD_W + 3;
  localparam int QW     = SUM_W - FRAC_BITS;

  localparam logic signed [SUM_W-1:0] HALF =
    {{(SUM_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
  localparam logic signed [QW-1:0] MAXV =
    {{(QW - WORD_WIDTH + 1){1'b0}}, {(WORD_WIDTH - 1){1'b1}}};
  localparam logic signed [QW-1:0] MINV =
    {{(QW - WORD_WIDTH + 1){1'b1}}, {(WORD_WIDTH - 1){1'b0}}};

  logic signed [PROD_W-1:0]     prod_r [mvt_pkg::NUM_LANES];
  logic signed [SUM_W-1:0]      sum_nxt;
  logic signed [SUM_W-1:0]      sum_r;
  logic signed [QW-1:0]         quot;
  logic signed [WORD_WIDTH-1:0] word;
  logic                         sat;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mvt_pkg::NUM_LANES; k++) begin
        prod_r[k] <= opa[k] * opb[k];
      end
      sum_r <= sum_nxt;
    end
  end

  // The exact sum plus half an LSB of the result, so a floor rounds to nearest.
  always_comb begin
    sum_nxt = HALF;
    for (int k = 0; k < mvt_pkg::NUM_LANES; k++) begin
      sum_nxt = sum_nxt + SUM_W'(prod_r[k]);
    end
  end

  assign quot = signed'(sum_r[SUM_W-1:FRAC_BITS]);

  always_comb begin
    if (quot > MAXV) begin
      word = MAXV[WORD_WIDTH-1:0];
      sat  = 1'b1;
    end else if (quot < MINV) begin
      word = MINV[WORD_WIDTH-1:0];
      sat  = 1'b1;
    end else begin
      word = quot[WORD_WIDTH-1:0];
      sat  = 1'b0;
    end
  end

  assign res.word = mvt_pkg::FIELD_W'(word);
  assign res.sat  = sat;

endmodule

// File: src/mvt_merge.sv
// ---------------------------------------------------------------------------
// mvt_merge: result merge and output register
// Gathers the four lane results, combines their saturation flags and holds
// the result for the output channel.
// ---------------------------------------------------------------------------
module mvt_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  mvt_pkg::pipe_tag_t           tag,
  input  mvt_pkg::lane_res_t           lane_res [mvt_pkg::NUM_LANES],
  output logic                         out_valid,
  output logic [mvt_pkg::FIELD_W-1:0]  out_res_x,
  output logic [mvt_pkg::FIELD_W-1:0]  out_res_y,
  output logic [mvt_pkg::FIELD_W-1:0]  out_res_z,
  output logic [mvt_pkg::FIELD_W-1:0]  out_res_w,
  output logic                         out_saturated
);

  logic                        valid_r;
  logic [mvt_pkg::FIELD_W-1:0] word_r [mvt_pkg::NUM_LANES];
  logic                        sat_r;
  logic                        sat_nxt;

  // The unused op code yields an all-zero result.
  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < mvt_pkg::NUM_LANES; i++) begin
      sat_nxt = sat_nxt | lane_res[i].sat;
    end
    sat_nxt = sat_nxt & ~tag.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < mvt_pkg::NUM_LANES; i++) begin
        word_r[i] <= tag.zero ? '0 : lane_res[i].word;
      end
      sat_r <= sat_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_res_x     = word_r[0];
  assign out_res_y     = word_r[1];
  assign out_res_z     = word_r[2];
  assign out_res_w     = word_r[3];
  assign out_saturated = sat_r;

endmodule

// File: src/matrix_vector_transform.sv
// ---------------------------------------------------------------------------
// matrix_vector_transform: 4x4 fixed-point matrix times 4-component vector
// Affine point, column product and row-vector product against a matrix
// held in configuration, rounded to nearest and saturated.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid / in_stall  op, coord_x..coord_w
//  out_      output     out_valid/out_stall  res_x..res_w, saturated
//  cfg_      input      cfg_wr_en            cfg_index, cfg_wdata
//
// One vector is taken every cycle unless the output is held; after its
// transfer a result passes the register stages operand select, products,
// sum, and saturate and merge. Sixteen multipliers, four per lane, sustain that rate.
// Reset restores the identity matrix and empties the pipeline at once.
// While a result waits under out_stall the whole pipeline holds, and in_stall
// is raised in the same cycle.
// ---------------------------------------------------------------------------
module matrix_vector_transform #(
  parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = mvt_pkg::WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [mvt_pkg::FIELD_W-1:0]   in_coord_x,
  input  logic [mvt_pkg::FIELD_W-1:0]   in_coord_y,
  input  logic [mvt_pkg::FIELD_W-1:0]   in_coord_z,
  input  logic [mvt_pkg::FIELD_W-1:0]   in_coord_w,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mvt_pkg::FIELD_W-1:0]   out_res_x,
  output logic [mvt_pkg::FIELD_W-1:0]   out_res_y,
  output logic [mvt_pkg::FIELD_W-1:0]   out_res_z,
  output logic [mvt_pkg::FIELD_W-1:0]   out_res_w,
  output logic                          out_saturated,
  input  logic                          cfg_wr_en,
  input  logic [mvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mvt_pkg::CFG_W-1:0]     cfg_wdata
);

  // Multiplier operands must also hold 1.0, which may not fit in one word.
  localparam int MUL_W = (WORD_WIDTH > FRAC_BITS + 2) ? WORD_WIDTH : FRAC_BITS + 2;
  localparam int NL    = mvt_pkg::NUM_LANES;

  localparam logic signed [MUL_W-1:0] ONE =
    {{(MUL_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  mvt_pkg::coef_mat_t  coef;
  logic                adv;
  logic signed [MUL_W-1:0] vec [NL];
  logic signed [MUL_W-1:0] cm [NL][NL];
  logic signed [MUL_W-1:0] opa_nxt [NL][NL];
  logic signed [MUL_W-1:0] opb_nxt [NL][NL];
  logic signed [MUL_W-1:0] opa_r [NL][NL];
  logic signed [MUL_W-1:0] opb_r [NL][NL];
  mvt_pkg::pipe_tag_t  tag1_r;
  mvt_pkg::pipe_tag_t  tag2_r;
  mvt_pkg::pipe_tag_t  tag3_r;
  mvt_pkg::pipe_tag_t  tag1_nxt;
  mvt_pkg::lane_res_t  lane_res [NL];
  logic [mvt_pkg::FIELD_W-1:0] coord [NL];
  logic signed [WORD_WIDTH-1:0] vw [NL];
  logic signed [WORD_WIDTH-1:0] cw [NL][NL];

  // The pipeline moves as a whole unless the output register is held.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  mvt_coef_bank u_coef_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  assign coord[0] = in_coord_x;
  assign coord[1] = in_coord_y;
  assign coord[2] = in_coord_z;
  assign coord[3] = in_coord_w;

  // Only the low WORD_WIDTH bits of each field and coefficient slot count.
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      vw[k]  = signed'(coord[k][WORD_WIDTH-1:0]);
      vec[k] = MUL_W'(vw[k]);
      for (int c = 0; c < NL; c++) begin
        cw[k][c] = signed'(coef[k][c][WORD_WIDTH-1:0]);
        cm[k][c] = MUL_W'(cw[k][c]);
      end
    end
  end

  // Operand routing: lane i forms result component i. In affine mode the
  // translation column is weighted by 1.0, and the w lane forms 1.0 * 1.0 so
  // that it is rounded and clipped along the same path as the others.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      for (int k = 0; k < NL; k++) begin
        opa_nxt[i][k] = '0;
        opb_nxt[i][k] = '0;
      end
    end
    case (in_op)
      mvt_pkg::OP_AFFINE: begin
        for (int i = 0; i < NL - 1; i++) begin
          for (int k = 0; k < NL - 1; k++) begin
            opa_nxt[i][k] = vec[k];
            opb_nxt[i][k] = cm[i][k];
          end
          opa_nxt[i][NL-1] = ONE;
          opb_nxt[i][NL-1] = cm[i][NL-1];
        end
        opa_nxt[NL-1][0] = ONE;
        opb_nxt[NL-1][0] = ONE;
      end
      mvt_pkg::OP_COLUMN: begin
        for (int i = 0; i < NL; i++) begin
          for (int k = 0; k < NL; k++) begin
            opa_nxt[i][k] = cm[i][k];
            opb_nxt[i][k] = vec[k];
          end
        end
      end
      mvt_pkg::OP_ROW: begin
        for (int i = 0; i < NL; i++) begin
          for (int k = 0; k < NL; k++) begin
            opa_nxt[i][k] = vec[k];
            opb_nxt[i][k] = cm[k][i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign tag1_nxt.vld  = in_valid;
  assign tag1_nxt.zero = (in_op == mvt_pkg::OP_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else if (adv) begin
      tag1_r <= tag1_nxt;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      opa_r <= opa_nxt;
      opb_r <= opb_nxt;
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    mvt_lane #(
      .FRAC_BITS  (FRAC_BITS),
      .WORD_WIDTH (WORD_WIDTH),
      .MUL_W      (MUL_W)
    ) u_lane (
      .clk (clk),
      .en  (adv),
      .opa (opa_r[g]),
      .opb (opb_r[g]),
      .res (lane_res[g])
    );
  end

  mvt_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .tag           (tag3_r),
    .lane_res      (lane_res),
    .out_valid     (out_valid),
    .out_res_x     (out_res_x),
    .out_res_y     (out_res_y),
    .out_res_z     (out_res_z),
    .out_res_w     (out_res_w),
    .out_saturated (out_saturated)
  );

`ifndef ASSERT_OFF
  // A transfer on the input channel always enters the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> tag1_r.vld)
    else $error("accepted vector did not enter the pipeline");

  // A held result freezes the last stage so that nothing is overwritten.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(tag3_r.vld) && $stable(tag3_r.zero)))
    else $error("pipeline moved while the output was held");

  // The unused op code leaves an all-zero result without saturation.
  a_zero_op: assert property (@(posedge clk) disable iff (!rst_n)
    (tag3_r.vld && tag3_r.zero && adv) |=>
      (out_valid && !out_saturated && (out_res_x == '0) && (out_res_w == '0)))
    else $error("unused op code produced a non-zero result");
`endif

endmodule
